FILE: src/assert_macros.svh
// Assertion macros used by the message ring top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define VLMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define VLMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/vlmr_pkg.sv
// Types, codes and constants shared by the message ring modules.
package vlmr_pkg;

  localparam int DEPTH_DEFAULT = 4096;
  localparam int CNT_W         = 13;
  localparam int LEN_W         = 16;
  localparam int HDR_BYTES     = 2;

  localparam logic [LEN_W-1:0] PAD_MARK  = 16'hFFFF;
  localparam logic [7:0]       BYTE_ONES = 8'hFF;

  // Request codes.
  localparam logic [2:0] REQ_RESERVE = 3'd0;
  localparam logic [2:0] REQ_PAYLOAD = 3'd1;
  localparam logic [2:0] REQ_COMMIT  = 3'd2;
  localparam logic [2:0] REQ_ABORT   = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;
  localparam logic [2:0] REQ_PEEK    = 3'd5;
  localparam logic [2:0] REQ_CLEAR   = 3'd6;

  // Memory operations issued by the controller.
  localparam logic [3:0] MOP_NONE    = 4'd0;
  localparam logic [3:0] MOP_TAIL_LO = 4'd1;
  localparam logic [3:0] MOP_TAIL_HI = 4'd2;
  localparam logic [3:0] MOP_PAD_LO  = 4'd3;
  localparam logic [3:0] MOP_PAD_HI  = 4'd4;
  localparam logic [3:0] MOP_WRAP_LO = 4'd5;
  localparam logic [3:0] MOP_WRAP_HI = 4'd6;
  localparam logic [3:0] MOP_PAYLOAD = 4'd7;
  localparam logic [3:0] MOP_HDR_LO  = 4'd8;
  localparam logic [3:0] MOP_HDR_HI  = 4'd9;
  localparam logic [3:0] MOP_DATA    = 4'd10;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       data_byte;
  } vlmr_req_t;

  typedef struct packed {
    logic             ok;
    logic [7:0]       read_byte;
    logic [LEN_W-1:0] head_len;
    logic             last_byte;
    logic [CNT_W-1:0] used_bytes;
    logic [CNT_W-1:0] free_bytes;
    logic             ring_empty;
  } vlmr_rsp_t;

  typedef struct packed {
    logic       load_req;
    logic [3:0] mop;
    logic       cap_lo;
    logic       cap_hi;
    logic       cap_data;
    logic       do_rsv_tail;
    logic       do_rsv_wrap;
    logic       do_payload;
    logic       do_commit;
    logic       do_abort;
    logic       do_clear;
    logic       do_skip;
    logic       do_consume;
    logic       do_off_inc;
    logic       set_ok;
    logic       set_hlen;
    logic       set_last;
    logic       out_load;
  } vlmr_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       rsv_gate;
    logic       tail_fit;
    logic       wrap_fit;
    logic       payload_ok;
    logic       commit_ok;
    logic       rsv_open;
    logic       used_zero;
    logic       hdr_pad;
    logic       off_ge_len;
    logic       off_next_ge_len;
    logic       out_free;
  } vlmr_sts_t;

endpackage

FILE: src/variable_length_message_ring_top.sv
// Message ring: a byte ring of variable-length messages, each behind a two-byte
// little-endian length header, with reserve, payload write, commit, abort, byte
// read, peek and clear requests. One request is handled at a time and returns one
// result. A reserve that does not fit at the tail writes a padding sentinel there and
// wraps to the start; a read or peek skips any padding sentinel at the head. Each
// result waits until the output register is free. Request timing is set by the
// single-port byte memory: header bytes are written and fetched one per cycle,
// with a registered read. A capacity write clears the ring and takes effect in
// the next cycle.
`include "assert_macros.svh"

module variable_length_message_ring_top #(
  parameter int STORE_DEPTH = vlmr_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  vlmr_pkg::vlmr_req_t        req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output vlmr_pkg::vlmr_rsp_t        rsp,
  input  logic                       cfg_we,
  input  logic [vlmr_pkg::CNT_W-1:0] cfg_wdata
);
  import vlmr_pkg::*;

  vlmr_cmd_t cmd;
  vlmr_sts_t sts;

  vlmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vlmr_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `VLMR_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
  `VLMR_ASSERT_NOW(a_last_needs_ok, rsp_valid && rsp.last_byte, rsp.ok, "last without success")
  `VLMR_ASSERT_NOW(a_byte_needs_ok, rsp_valid && (rsp.read_byte != 8'd0), rsp.ok, "data on failure")

endmodule

FILE: src/vlmr_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module vlmr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  vlmr_pkg::vlmr_sts_t sts,
  output vlmr_pkg::vlmr_cmd_t cmd
);
  import vlmr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_T0    = 4'd2;
  localparam logic [3:0] S_T1    = 4'd3;
  localparam logic [3:0] S_P0    = 4'd4;
  localparam logic [3:0] S_P1    = 4'd5;
  localparam logic [3:0] S_P2    = 4'd6;
  localparam logic [3:0] S_P3    = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_HLO   = 4'd9;
  localparam logic [3:0] S_HHI   = 4'd10;
  localparam logic [3:0] S_HCAP  = 4'd11;
  localparam logic [3:0] S_HEVAL = 4'd12;
  localparam logic [3:0] S_DRQ   = 4'd13;
  localparam logic [3:0] S_DCAP  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state, state_next;
  logic       post, post_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      post  <= 1'b0;
    end else begin
      state <= state_next;
      post  <= post_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    post_next  = post;
    req_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          post_next    = 1'b0;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_DONE;
        case (sts.req_type)
          REQ_RESERVE: begin
            if (sts.rsv_gate && sts.tail_fit) begin
              cmd.do_rsv_tail = 1'b1;
              cmd.set_ok      = 1'b1;
              state_next      = S_T0;
            end else if (sts.rsv_gate && sts.wrap_fit) begin
              cmd.do_rsv_wrap = 1'b1;
              cmd.set_ok      = 1'b1;
              state_next      = S_P0;
            end
          end
          REQ_PAYLOAD: begin
            if (sts.payload_ok) begin
              cmd.do_payload = 1'b1;
              cmd.set_ok     = 1'b1;
              cmd.mop        = MOP_PAYLOAD;
            end
          end
          REQ_COMMIT: begin
            if (sts.commit_ok) begin
              cmd.do_commit = 1'b1;
              cmd.set_ok    = 1'b1;
            end
          end
          REQ_ABORT: begin
            cmd.do_abort = 1'b1;
            cmd.set_ok   = sts.rsv_open;
          end
          REQ_READ, REQ_PEEK: begin
            state_next = S_CHK;
          end
          REQ_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.set_ok   = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_T0: begin
        cmd.mop    = MOP_TAIL_LO;
        state_next = S_T1;
      end
      S_T1: begin
        cmd.mop    = MOP_TAIL_HI;
        state_next = S_DONE;
      end
      S_P0: begin
        cmd.mop    = MOP_PAD_LO;
        state_next = S_P1;
      end
      S_P1: begin
        cmd.mop    = MOP_PAD_HI;
        state_next = S_P2;
      end
      S_P2: begin
        cmd.mop    = MOP_WRAP_LO;
        state_next = S_P3;
      end
      S_P3: begin
        cmd.mop    = MOP_WRAP_HI;
        state_next = S_DONE;
      end
      S_CHK: begin
        state_next = sts.used_zero ? S_DONE : S_HLO;
      end
      S_HLO: begin
        cmd.mop    = MOP_HDR_LO;
        state_next = S_HHI;
      end
      S_HHI: begin
        cmd.mop    = MOP_HDR_HI;
        cmd.cap_lo = 1'b1;
        state_next = S_HCAP;
      end
      S_HCAP: begin
        cmd.cap_hi = 1'b1;
        state_next = S_HEVAL;
      end
      S_HEVAL: begin
        // A padding sentinel at the head is dropped before anything else.
        if (sts.hdr_pad) begin
          cmd.do_skip = 1'b1;
          state_next  = S_CHK;
        end else if (post) begin
          state_next = S_DONE;
        end else if (sts.req_type == REQ_PEEK) begin
          cmd.set_ok   = 1'b1;
          cmd.set_hlen = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.set_ok   = 1'b1;
          cmd.set_hlen = 1'b1;
          if (sts.off_ge_len) begin
            cmd.set_last   = 1'b1;
            cmd.do_consume = 1'b1;
            post_next      = 1'b1;
            state_next     = S_CHK;
          end else begin
            state_next = S_DRQ;
          end
        end
      end
      S_DRQ: begin
        cmd.mop    = MOP_DATA;
        state_next = S_DCAP;
      end
      S_DCAP: begin
        cmd.cap_data   = 1'b1;
        cmd.do_off_inc = 1'b1;
        if (sts.off_next_ge_len) begin
          cmd.set_last   = 1'b1;
          cmd.do_consume = 1'b1;
          post_next      = 1'b1;
          state_next     = S_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/vlmr_dp.sv
// Datapath: byte store, ring pointers, reservation state and result register.
module vlmr_dp #(
  parameter int STORE_DEPTH = vlmr_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vlmr_pkg::vlmr_req_t          req,
  input  logic                         cfg_we,
  input  logic [vlmr_pkg::CNT_W-1:0]   cfg_wdata,
  input  vlmr_pkg::vlmr_cmd_t          cmd,
  output vlmr_pkg::vlmr_sts_t          sts,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output vlmr_pkg::vlmr_rsp_t          rsp
);
  import vlmr_pkg::*;

  localparam int PTR_W     = $clog2(STORE_DEPTH);
  localparam int AW        = 18;
  localparam int CAP_RESET = (STORE_DEPTH < 4096) ? STORE_DEPTH : 4096;
  localparam logic [AW-1:0] HDR_X = AW'(HDR_BYTES);

  logic [7:0]       mem [STORE_DEPTH];
  logic [PTR_W-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             mem_we;

  logic [CNT_W-1:0] cap, used, rsv_foot;
  logic [PTR_W-1:0] wr_pos, rd_pos, rsv_ptr;
  logic [LEN_W-1:0] rsv_rem, rd_off, hdr;
  logic             rsv_open;
  vlmr_req_t        cur;
  logic             res_ok, res_last;
  logic [7:0]       res_byte;
  logic [LEN_W-1:0] res_hlen;

  logic [AW-1:0] cap_x, used_x, p_x, rec_x, free_x, tail_room, foot_x;
  logic [AW-1:0] hdr_x, crec_x, rd_x, cons_sum, cons_pos, used_cons;
  logic [AW-1:0] tail_x, used_skip, wsum, wr_next, used_sum, used_commit;
  logic [AW-1:0] cfg_x, cap_clamp, data_x;
  logic          tail_fit, wrap_fit;

  // Placement arithmetic for a reserve request.
  always_comb begin
    cap_x     = AW'(cap);
    used_x    = AW'(used);
    p_x       = AW'(wr_pos);
    rec_x     = AW'(cur.msg_len) + HDR_X;
    free_x    = cap_x - used_x;
    tail_room = cap_x - p_x;
    foot_x    = tail_room + rec_x;
    tail_fit  = (tail_room >= rec_x) &&
                ((tail_room == rec_x) || (tail_room - rec_x >= HDR_X)) &&
                (free_x >= rec_x);
    wrap_fit  = (cap_x >= rec_x) &&
                ((cap_x == rec_x) || (cap_x - rec_x >= HDR_X)) &&
                (tail_room >= HDR_X) && (free_x >= foot_x);
  end

  // Pointer arithmetic for consume, padding skip and commit, plus the data address and capacity clamp.
  always_comb begin
    hdr_x       = AW'(hdr);
    crec_x      = hdr_x + HDR_X;
    rd_x        = AW'(rd_pos);
    cons_sum    = rd_x + crec_x;
    cons_pos    = (cons_sum >= cap_x) ? cons_sum - cap_x : cons_sum;
    used_cons   = (used_x > crec_x) ? used_x - crec_x : '0;
    tail_x      = cap_x - rd_x;
    used_skip   = (used_x > tail_x) ? used_x - tail_x : '0;
    wsum        = p_x + AW'(rsv_foot);
    wr_next     = (wsum >= cap_x) ? wsum - cap_x : wsum;
    used_sum    = used_x + AW'(rsv_foot);
    used_commit = (used_sum > cap_x) ? cap_x : used_sum;
    data_x      = rd_x + HDR_X + AW'(rd_off);
    cfg_x       = AW'(cfg_wdata);
    if (cfg_x < HDR_X) begin
      cap_clamp = HDR_X;
    end else if (cfg_x > AW'(STORE_DEPTH)) begin
      cap_clamp = AW'(STORE_DEPTH);
    end else begin
      cap_clamp = cfg_x;
    end
  end

  always_comb begin
    sts.req_type        = cur.req_type;
    sts.rsv_gate        = !rsv_open && (cur.msg_len != PAD_MARK);
    sts.tail_fit        = tail_fit;
    sts.wrap_fit        = wrap_fit;
    sts.payload_ok      = rsv_open && (rsv_rem != '0);
    sts.commit_ok       = rsv_open && (rsv_rem == '0);
    sts.rsv_open        = rsv_open;
    sts.used_zero       = (used == '0);
    sts.hdr_pad         = (hdr == PAD_MARK);
    sts.off_ge_len      = (rd_off >= hdr);
    sts.off_next_ge_len = ((17'(rd_off) + 17'd1) >= 17'(hdr));
    sts.out_free        = !rsp_valid || rsp_ready;
  end

  // Header bytes never straddle the end of the ring, so no wrap is needed here.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = rd_pos;
    mem_wdata = cur.data_byte;
    case (cmd.mop)
      MOP_TAIL_LO: begin
        mem_we    = 1'b1;
        mem_addr  = wr_pos;
        mem_wdata = cur.msg_len[7:0];
      end
      MOP_TAIL_HI: begin
        mem_we    = 1'b1;
        mem_addr  = wr_pos + PTR_W'(1);
        mem_wdata = cur.msg_len[15:8];
      end
      MOP_PAD_LO: begin
        mem_we    = 1'b1;
        mem_addr  = wr_pos;
        mem_wdata = BYTE_ONES;
      end
      MOP_PAD_HI: begin
        mem_we    = 1'b1;
        mem_addr  = wr_pos + PTR_W'(1);
        mem_wdata = BYTE_ONES;
      end
      MOP_WRAP_LO: begin
        mem_we    = 1'b1;
        mem_addr  = '0;
        mem_wdata = cur.msg_len[7:0];
      end
      MOP_WRAP_HI: begin
        mem_we    = 1'b1;
        mem_addr  = PTR_W'(1);
        mem_wdata = cur.msg_len[15:8];
      end
      MOP_PAYLOAD: begin
        mem_we    = 1'b1;
        mem_addr  = rsv_ptr;
        mem_wdata = cur.data_byte;
      end
      MOP_HDR_LO: begin
        mem_addr = rd_pos;
      end
      MOP_HDR_HI: begin
        mem_addr = rd_pos + PTR_W'(1);
      end
      MOP_DATA: begin
        mem_addr = PTR_W'(data_x);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CNT_W'(CAP_RESET);
      used      <= '0;
      wr_pos    <= '0;
      rd_pos    <= '0;
      rsv_open  <= 1'b0;
      rsv_foot  <= '0;
      rsv_ptr   <= '0;
      rsv_rem   <= '0;
      rd_off    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we || cmd.do_clear) begin
        used     <= '0;
        wr_pos   <= '0;
        rd_pos   <= '0;
        rsv_open <= 1'b0;
        rsv_foot <= '0;
        rsv_ptr  <= '0;
        rsv_rem  <= '0;
        rd_off   <= '0;
      end
      if (cfg_we) begin
        cap <= CNT_W'(cap_clamp);
      end
      if (cmd.do_rsv_tail) begin
        rsv_ptr  <= wr_pos + PTR_W'(HDR_BYTES);
        rsv_foot <= CNT_W'(rec_x);
        rsv_rem  <= cur.msg_len;
        rsv_open <= 1'b1;
      end
      if (cmd.do_rsv_wrap) begin
        rsv_ptr  <= PTR_W'(HDR_BYTES);
        rsv_foot <= CNT_W'(foot_x);
        rsv_rem  <= cur.msg_len;
        rsv_open <= 1'b1;
      end
      if (cmd.do_payload) begin
        rsv_ptr <= rsv_ptr + PTR_W'(1);
        rsv_rem <= rsv_rem - LEN_W'(1);
      end
      if (cmd.do_commit) begin
        wr_pos   <= PTR_W'(wr_next);
        used     <= CNT_W'(used_commit);
        rsv_open <= 1'b0;
        rsv_foot <= '0;
        rsv_ptr  <= '0;
      end
      if (cmd.do_abort) begin
        rsv_open <= 1'b0;
        rsv_foot <= '0;
        rsv_ptr  <= '0;
        rsv_rem  <= '0;
      end
      if (cmd.do_skip) begin
        used   <= CNT_W'(used_skip);
        rd_pos <= '0;
      end
      // Consuming the head message takes priority over the offset step.
      if (cmd.do_consume) begin
        rd_pos <= PTR_W'(cons_pos);
        used   <= CNT_W'(used_cons);
        rd_off <= '0;
      end else if (cmd.do_off_inc) begin
        rd_off <= rd_off + LEN_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur      <= req;
      res_ok   <= 1'b0;
      res_byte <= '0;
      res_hlen <= '0;
      res_last <= 1'b0;
    end
    if (cmd.cap_lo) begin
      hdr[7:0] <= mem_rdata;
    end
    if (cmd.cap_hi) begin
      hdr[15:8] <= mem_rdata;
    end
    if (cmd.cap_data) begin
      res_byte <= mem_rdata;
    end
    if (cmd.set_ok) begin
      res_ok <= 1'b1;
    end
    if (cmd.set_hlen) begin
      res_hlen <= hdr;
    end
    if (cmd.set_last) begin
      res_last <= 1'b1;
    end
    if (cmd.out_load) begin
      rsp.ok         <= res_ok;
      rsp.read_byte  <= res_byte;
      rsp.head_len   <= res_hlen;
      rsp.last_byte  <= res_last;
      rsp.used_bytes <= used;
      rsp.free_bytes <= cap - used;
      rsp.ring_empty <= (used == '0);
    end
  end

endmodule

FILE: bench/tb_variable_length_message_ring_top.sv
// Testbench for the message ring: directed and random traffic checked against an in-bench ring predictor.
module tb_variable_length_message_ring_top;
  import vlmr_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int MEM_DEPTH = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  vlmr_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  vlmr_rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  variable_length_message_ring_top uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring predictor state.
  logic [7:0] ring_mem [0:MEM_DEPTH-1];
  int ring_cap = MEM_DEPTH;
  int wr_pos, rd_pos, used_cnt, rsv_foot, rsv_ptr, rsv_left, rd_off;
  bit rsv_open;

  vlmr_rsp_t expected_q[$];
  vlmr_rsp_t last_pred;
  vlmr_rsp_t got_exp;
  bit failed = 1'b0;
  int sent_count = 0;
  int burst_left = 0;
  bit hold_toggle = 1'b0;

  function automatic int hdr_at(int p);
    return int'({ring_mem[(p + 1) % ring_cap], ring_mem[p % ring_cap]});
  endfunction

  function automatic void put_hdr(int p, int v);
    ring_mem[p % ring_cap] = v[7:0];
    ring_mem[(p + 1) % ring_cap] = v[15:8];
  endfunction

  function automatic void ring_clear();
    wr_pos = 0; rd_pos = 0; used_cnt = 0; rsv_open = 1'b0;
    rsv_foot = 0; rsv_ptr = 0; rsv_left = 0; rd_off = 0;
  endfunction

  function automatic void skip_pad();
    int tail;
    if (used_cnt == 0 || hdr_at(rd_pos) != int'(PAD_MARK)) return;
    tail = ring_cap - rd_pos;
    used_cnt = used_cnt > tail ? used_cnt - tail : 0;
    rd_pos = 0;
  endfunction

  function automatic void consume_head(int rec);
    rd_pos = (rd_pos + rec) % ring_cap;
    used_cnt = used_cnt > rec ? used_cnt - rec : 0;
    rd_off = 0;
    skip_pad();
  endfunction

  function automatic bit try_reserve(int len);
    int rec, freeb, tail_room, foot;
    if (rsv_open || len == int'(PAD_MARK)) return 1'b0;
    rec = HDR_BYTES + len;
    freeb = ring_cap - used_cnt;
    tail_room = ring_cap - wr_pos;
    if (tail_room >= rec && (tail_room == rec || tail_room - rec >= HDR_BYTES) &&
        freeb >= rec) begin
      put_hdr(wr_pos, len);
      rsv_ptr = wr_pos + HDR_BYTES;
      rsv_foot = rec;
    end else begin
      foot = tail_room + rec;
      if (!(ring_cap >= rec && (ring_cap == rec || ring_cap - rec >= HDR_BYTES) &&
            tail_room >= HDR_BYTES && freeb >= foot)) return 1'b0;
      // Pad out the tail and place the message at the start of the ring.
      put_hdr(wr_pos, int'(PAD_MARK));
      put_hdr(0, len);
      rsv_ptr = HDR_BYTES;
      rsv_foot = foot;
    end
    rsv_left = len;
    rsv_open = 1'b1;
    return 1'b1;
  endfunction

  function automatic void set_capacity(logic [CNT_W-1:0] v);
    int c;
    c = int'(v);
    if (c < 2) c = 2;
    if (c > MEM_DEPTH) c = MEM_DEPTH;
    ring_cap = c;
    ring_clear();
  endfunction

  function automatic vlmr_rsp_t predict_ring(vlmr_req_t r);
    vlmr_rsp_t o;
    int len;
    o = '0;
    case (r.req_type)
      REQ_RESERVE: o.ok = try_reserve(int'(r.msg_len));
      REQ_PAYLOAD: begin
        if (rsv_open && rsv_left > 0) begin
          ring_mem[rsv_ptr % ring_cap] = r.data_byte;
          rsv_ptr++;
          rsv_left--;
          o.ok = 1'b1;
        end
      end
      REQ_COMMIT: begin
        if (rsv_open && rsv_left == 0) begin
          wr_pos = (wr_pos + rsv_foot) % ring_cap;
          used_cnt += rsv_foot;
          if (used_cnt > ring_cap) used_cnt = ring_cap;
          rsv_open = 1'b0; rsv_foot = 0; rsv_ptr = 0;
          o.ok = 1'b1;
        end
      end
      REQ_ABORT: begin
        o.ok = rsv_open;
        rsv_open = 1'b0; rsv_foot = 0; rsv_ptr = 0; rsv_left = 0;
      end
      REQ_READ: begin
        skip_pad();
        if (used_cnt != 0) begin
          len = hdr_at(rd_pos);
          o.ok = 1'b1;
          o.head_len = 16'(len);
          if (rd_off >= len) begin
            // Zero-length message: one read consumes it.
            o.last_byte = 1'b1;
            consume_head(HDR_BYTES + len);
          end else begin
            o.read_byte = ring_mem[(rd_pos + HDR_BYTES + rd_off) % ring_cap];
            rd_off++;
            if (rd_off >= len) begin
              o.last_byte = 1'b1;
              consume_head(HDR_BYTES + len);
            end
          end
        end
      end
      REQ_PEEK: begin
        skip_pad();
        if (used_cnt != 0) begin
          o.ok = 1'b1;
          o.head_len = 16'(hdr_at(rd_pos));
        end
      end
      REQ_CLEAR: begin
        ring_clear();
        o.ok = 1'b1;
      end
      default: ;
    endcase
    o.used_bytes = CNT_W'(used_cnt);
    o.free_bytes = CNT_W'(ring_cap - used_cnt);
    o.ring_empty = (used_cnt == 0);
    return o;
  endfunction

  // Sends one request; valid stays high on return so a following item can go back to back.
  task automatic send_item(input logic [2:0] kind, input logic [15:0] len,
                           input logic [7:0] data);
    vlmr_req_t r;
    r.req_type = kind;
    r.msg_len = len;
    r.data_byte = data;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    last_pred = predict_ring(r);
    expected_q.push_back(last_pred);
    sent_count++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_capacity(v);
    @(posedge clk);
  endtask

  task automatic put_message(input int len, input bit finish);
    send_item(REQ_RESERVE, 16'(len), 8'($urandom));
    if (!last_pred.ok) return;
    for (int i = 0; i < len; i++) send_item(REQ_PAYLOAD, 16'($urandom), 8'($urandom));
    send_item(finish ? REQ_COMMIT : REQ_ABORT, 16'($urandom), 8'($urandom));
  endtask

  task automatic drain_message();
    int guard;
    guard = 0;
    do begin
      send_item(REQ_READ, 16'($urandom), 8'($urandom));
      guard++;
    end while (last_pred.ok && !last_pred.last_byte && guard < 400);
  endtask

  task automatic test_directed();
    send_item(REQ_READ, 16'h0000, 8'h00);
    send_item(REQ_PEEK, 16'hFFFF, 8'hFF);
    send_item(REQ_UNUSED, 16'h1234, 8'h56);
    send_item(REQ_PAYLOAD, 16'h0000, 8'hAA);
    send_item(REQ_COMMIT, 16'h0000, 8'h00);
    send_item(REQ_ABORT, 16'h0000, 8'h00);
    send_item(REQ_RESERVE, 16'hFFFF, 8'h00);
    send_item(REQ_RESERVE, 16'd5000, 8'h00);
    send_item(REQ_RESERVE, 16'd0, 8'h00);
    send_item(REQ_COMMIT, 16'd0, 8'h00);
    send_item(REQ_READ, 16'd0, 8'h00);
    send_item(REQ_RESERVE, 16'd3, 8'h00);
    send_item(REQ_RESERVE, 16'd1, 8'h00);
    send_item(REQ_PAYLOAD, 16'd0, 8'h00);
    send_item(REQ_COMMIT, 16'd0, 8'h00);
    send_item(REQ_PAYLOAD, 16'd0, 8'hFF);
    send_item(REQ_PAYLOAD, 16'd0, 8'h5A);
    send_item(REQ_PAYLOAD, 16'd0, 8'hA5);
    send_item(REQ_COMMIT, 16'd0, 8'h00);
    send_item(REQ_PEEK, 16'd0, 8'h00);
    drain_message();
    send_item(REQ_RESERVE, 16'd2, 8'h00);
    send_item(REQ_ABORT, 16'd0, 8'h00);
    send_item(REQ_CLEAR, 16'd0, 8'h00);
  endtask

  // A small ring makes the tail padding and wrap frequent.
  task automatic test_wrap_and_padding();
    write_capacity(13'd16);
    for (int i = 0; i < 12; i++) begin
      put_message($urandom_range(0, 9), 1'b1);
      if ($urandom_range(1, 3) != 1) drain_message();
    end
    for (int i = 0; i < 6; i++) drain_message();
  endtask

  task automatic test_capacity_extremes();
    write_capacity(13'd0);
    put_message(0, 1'b1);
    put_message(1, 1'b1);
    drain_message();
    write_capacity(13'd2);
    put_message(0, 1'b1);
    put_message(0, 1'b1);
    drain_message();
    write_capacity(13'h1FFF);
    put_message(40, 1'b1);
    drain_message();
    // A message that fills the whole ring exactly.
    write_capacity(13'd64);
    put_message(62, 1'b1);
    drain_message();
    write_capacity(13'd4096);
    put_message(100, 1'b1);
    drain_message();
  endtask

  task automatic test_full_ring_stall();
    write_capacity(13'd4096);
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 10; i++) put_message($urandom_range(0, 4), 1'b1);
    for (int i = 0; i < 10; i++) drain_message();
  endtask

  task automatic test_random_traffic();
    int pick, len;
    logic [CNT_W-1:0] caps [0:8];
    caps = '{13'd2, 13'd3, 13'd5, 13'd8, 13'd17, 13'd64, 13'd200, 13'd4096, 13'd0};
    while (sent_count < 1850) begin
      if ($urandom_range(0, 299) == 0) begin
        pick = $urandom_range(0, 8);
        write_capacity(pick == 8 ? 13'($urandom_range(2, 300)) : caps[pick]);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, ring_cap < 300 ? ring_cap : 300)
                                           : $urandom_range(0, 12);
        put_message(len, $urandom_range(0, 9) != 0);
        // Occasionally the writer sends one payload byte too many.
        if ($urandom_range(0, 19) == 0) send_item(REQ_PAYLOAD, 16'($urandom), 8'($urandom));
      end else if (pick < 78) begin
        drain_message();
      end else if (pick < 84) begin
        send_item(REQ_PEEK, 16'($urandom), 8'($urandom));
      end else if (pick < 86) begin
        send_item(REQ_CLEAR, 16'($urandom), 8'($urandom));
      end else begin
        send_item(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Result checker with its own ready pattern and a long hold on request.
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_seen = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation waiting");
          failed = 1'b1;
        end else begin
          got_exp = expected_q.pop_front();
          if (rsp.ok !== got_exp.ok) begin
            $error("ok: expected %0d actual %0d", got_exp.ok, rsp.ok); failed = 1'b1;
          end
          if (rsp.read_byte !== got_exp.read_byte) begin
            $error("read_byte: expected %0h actual %0h", got_exp.read_byte, rsp.read_byte);
            failed = 1'b1;
          end
          if (rsp.head_len !== got_exp.head_len) begin
            $error("head_len: expected %0d actual %0d", got_exp.head_len, rsp.head_len);
            failed = 1'b1;
          end
          if (rsp.last_byte !== got_exp.last_byte) begin
            $error("last_byte: expected %0d actual %0d", got_exp.last_byte, rsp.last_byte);
            failed = 1'b1;
          end
          if (rsp.used_bytes !== got_exp.used_bytes) begin
            $error("used_bytes: expected %0d actual %0d", got_exp.used_bytes, rsp.used_bytes);
            failed = 1'b1;
          end
          if (rsp.free_bytes !== got_exp.free_bytes) begin
            $error("free_bytes: expected %0d actual %0d", got_exp.free_bytes, rsp.free_bytes);
            failed = 1'b1;
          end
          if (rsp.ring_empty !== got_exp.ring_empty) begin
            $error("ring_empty: expected %0d actual %0d", got_exp.ring_empty, rsp.ring_empty);
            failed = 1'b1;
          end
        end
      end
      rx_cycle++;
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 150) % 3)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          default: rsp_ready <= (rx_cycle % 5) == 0;
        endcase
      end
    end
  end

  initial begin
    set_capacity(13'd4096);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_wrap_and_padding();
    test_capacity_extremes();
    test_full_ring_stall();
    test_random_traffic();
    wait_idle();
    if (!failed && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/vlmr_pkg.sv
src/vlmr_ctrl.sv
src/vlmr_dp.sv
src/variable_length_message_ring_top.sv
bench/tb_variable_length_message_ring_top.sv
